@@ rtl/ordered_set_successor_engine_defines.svh @@
// -----------------------------------------------------------------------------
// ordered_set_successor_engine_defines
// Assertion macros for the ordered set engine.
// -----------------------------------------------------------------------------
`ifndef ORDERED_SET_SUCCESSOR_ENGINE_DEFINES_SVH
`define ORDERED_SET_SUCCESSOR_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define OSE_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define OSE_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define OSE_ASSERT_IMPL(label, clk, rst_n, prop)
`define OSE_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ rtl/ose_pkg.sv @@
// -----------------------------------------------------------------------------
// ose_pkg
// Types and constants shared by the ordered set engine.
// -----------------------------------------------------------------------------
package ose_pkg;
	localparam int unsigned CAPACITY_DEFAULT = 64;

	typedef enum logic [2:0] {
		CMD_INSERT = 3'd0,
		CMD_DELETE = 3'd1,
		CMD_EXISTS = 3'd2,
		CMD_NEXT   = 3'd3,
		CMD_PREV   = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT_UP,
		ST_SHIFT_DOWN,
		ST_FETCH,
		ST_REPLY
	} state_t;
endpackage

@@ rtl/ose_if.sv @@
// -----------------------------------------------------------------------------
// ose_cmd_if / ose_rsp_if
// Valid/ready channels for commands and results.
// -----------------------------------------------------------------------------
interface ose_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic signed [31:0] key;
	modport source (output valid, command, key, input ready);
	modport sink   (input valid, command, key, output ready);
endinterface

interface ose_rsp_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic        found;
	logic signed [31:0] neighbour_key;
	modport source (output valid, status, found, neighbour_key, input ready);
	modport sink   (input valid, status, found, neighbour_key, output ready);
endinterface

@@ rtl/ose_ram.sv @@
// -----------------------------------------------------------------------------
// ose_ram
// Single-port-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module ose_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/ordered_set_successor_engine.sv @@
// -----------------------------------------------------------------------------
// ordered_set_successor_engine
// Sorted key store with insert, delete, exists, next and prev commands.
// -----------------------------------------------------------------------------
// Usage: commands arrive on cmd (command, key); each transfer gives exactly
// one result on rsp (status, found, neighbour_key). One command is worked on
// at a time; cmd.ready is high only when the engine is idle and holds no result.
// A linear scan through the key RAM, one entry per cycle, finds the first
// key not less than the given key, or runs off the end. Insert then shifts
// the tail up one entry per cycle; delete needs a read and a write per moved
// entry; next/prev fetch the neighbour from the RAM. A reply state follows,
// which raises rsp.valid. A new command can be taken in the cycle after the
// result transfer. The key RAM has a single read port.
// Reset clears the key count, so the set is empty; RAM contents are not
// cleared and entries beyond the count are never used.
// When rsp is stalled, the result holds in its output register and the
// engine accepts no further command until it is taken.
// -----------------------------------------------------------------------------
`include "ordered_set_successor_engine_defines.svh"

module ordered_set_successor_engine #(
	parameter int unsigned CAPACITY = ose_pkg::CAPACITY_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	ose_cmd_if.sink   cmd,
	ose_rsp_if.source rsp
);
	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	ose_pkg::state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;      // scan / shift index
	logic [CW-1:0] pos_q, pos_d;
	logic [2:0]    cmd_q, cmd_d;
	logic signed [31:0] key_q, key_d;
	logic signed [31:0] hold_q, hold_d; // data carried during shift up
	logic          rd_pend_q, rd_pend_d;
	logic          rv_q, rv_d, rst_q, rst_d, rf_q, rf_d;
	logic signed [31:0] rk_q, rk_d;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wdata, rdata;
	logic signed [31:0] rdata_s;
	logic [CW-1:0] raddr_w;

	assign rdata_s = signed'(rdata);
	assign raddr   = raddr_w[AW-1:0];

	ose_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign cmd.ready         = (state_q == ose_pkg::ST_IDLE) && !rv_q;
	assign rsp.valid         = rv_q;
	assign rsp.status        = rst_q;
	assign rsp.found         = rf_q;
	assign rsp.neighbour_key = rk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ose_pkg::ST_IDLE;
			count_q   <= '0;
			rv_q      <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			rv_q      <= rv_d;
			rd_pend_q <= rd_pend_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		pos_q  <= pos_d;
		cmd_q  <= cmd_d;
		key_q  <= key_d;
		hold_q <= hold_d;
		rst_q  <= rst_d;
		rf_q   <= rf_d;
		rk_q   <= rk_d;
	end

	// Scan protocol: rd_pend_q marks that rdata holds entry idx_q-1.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		pos_d     = pos_q;
		cmd_d     = cmd_q;
		key_d     = key_q;
		hold_d    = hold_q;
		rd_pend_d = 1'b0;
		rv_d      = rv_q;
		rst_d     = rst_q;
		rf_d      = rf_q;
		rk_d      = rk_q;
		we        = 1'b0;
		waddr     = '0;
		wdata     = '0;
		raddr_w   = idx_q;
		if (rv_q && rsp.ready) begin
			rv_d = 1'b0;
		end
		case (state_q)
			ose_pkg::ST_IDLE: begin
				if (cmd.valid && cmd.ready) begin
					cmd_d   = cmd.command;
					key_d   = cmd.key;
					idx_d   = '0;
					state_d = ose_pkg::ST_SEARCH;
				end
			end
			ose_pkg::ST_SEARCH: begin
				// compare the entry read last cycle, then issue the next read
				if (rd_pend_q && rdata_s >= key_q) begin
					pos_d   = idx_q - 1'b1;
					state_d = ose_pkg::ST_REPLY;
				end else if (idx_q >= count_q) begin
					pos_d   = count_q;
					state_d = ose_pkg::ST_REPLY;
				end else begin
					raddr_w   = idx_q;
					idx_d     = idx_q + 1'b1;
					rd_pend_d = 1'b1;
				end
				if (state_d == ose_pkg::ST_REPLY) begin
					// present: rdata holds entry pos when stopped by compare
					hold_d = (rd_pend_q && rdata_s >= key_q) ? rdata_s : key_q;
					rf_d   = rd_pend_q && rdata_s == key_q;
					rst_d  = 1'b0;
					rk_d   = '0;
					case (cmd_q)
						ose_pkg::CMD_INSERT: begin
							if (rd_pend_q && rdata_s == key_q) begin
								state_d = ose_pkg::ST_REPLY;
							end else if (count_q >= CW'(CAPACITY)) begin
								rst_d   = 1'b1;
							end else begin
								// write key at pos, carry displaced entries up
								state_d = ose_pkg::ST_SHIFT_UP;
							end
						end
						ose_pkg::CMD_DELETE: begin
							if (rd_pend_q && rdata_s == key_q) begin
								state_d = ose_pkg::ST_SHIFT_DOWN;
							end
						end
						ose_pkg::CMD_NEXT: begin
							state_d = ose_pkg::ST_FETCH;
						end
						ose_pkg::CMD_PREV: begin
							state_d = ose_pkg::ST_FETCH;
						end
						default: ;
					endcase
					idx_d = pos_d;
				end
			end
			ose_pkg::ST_SHIFT_UP: begin
				// first cycle: hold_q=found entry (or key if at end); idx=pos
				if (!rd_pend_q) begin
					if (idx_q == count_q) begin
						we      = 1'b1;
						waddr   = idx_q[AW-1:0];
						wdata   = key_q;
						count_d = count_q + 1'b1;
						state_d = ose_pkg::ST_REPLY;
					end else begin
						// entry idx still equals hold_q; write key, carry old
						we      = 1'b1;
						waddr   = idx_q[AW-1:0];
						wdata   = key_q;
						key_d   = hold_q;
						idx_d   = idx_q + 1'b1;
						raddr_w = idx_q + 1'b1;
						rd_pend_d = 1'b1;
					end
				end else begin
					if (idx_q == count_q) begin
						we      = 1'b1;
						waddr   = idx_q[AW-1:0];
						wdata   = key_q;
						count_d = count_q + 1'b1;
						state_d = ose_pkg::ST_REPLY;
					end else begin
						we      = 1'b1;
						waddr   = idx_q[AW-1:0];
						wdata   = key_q;
						key_d   = rdata_s;
						idx_d   = idx_q + 1'b1;
						raddr_w = idx_q + 1'b1;
						rd_pend_d = 1'b1;
					end
				end
			end
			ose_pkg::ST_SHIFT_DOWN: begin
				// read idx+1, then write it at idx
				if (rd_pend_q) begin
					we    = 1'b1;
					waddr = idx_q[AW-1:0];
					wdata = rdata_s;
					idx_d = idx_q + 1'b1;
				end else if (idx_q + 1'b1 >= count_q) begin
					count_d = count_q - 1'b1;
					state_d = ose_pkg::ST_REPLY;
				end else begin
					raddr_w   = idx_q + 1'b1;
					rd_pend_d = 1'b1;
				end
			end
			ose_pkg::ST_FETCH: begin
				if (rd_pend_q) begin
					rf_d    = 1'b1;
					rk_d    = rdata_s;
					state_d = ose_pkg::ST_REPLY;
				end else begin
					rf_d    = 1'b0;
					state_d = ose_pkg::ST_REPLY;
					if (cmd_q == ose_pkg::CMD_NEXT) begin
						// skip a matching key
						if (rf_q) begin
							if (pos_q + 1'b1 < count_q) begin
								raddr_w   = pos_q + 1'b1;
								rd_pend_d = 1'b1;
								state_d   = ose_pkg::ST_FETCH;
							end
						end else if (pos_q < count_q) begin
							raddr_w   = pos_q;
							rd_pend_d = 1'b1;
							state_d   = ose_pkg::ST_FETCH;
						end
					end else if (pos_q != '0) begin
						raddr_w   = pos_q - 1'b1;
						rd_pend_d = 1'b1;
						state_d   = ose_pkg::ST_FETCH;
					end
				end
			end
			ose_pkg::ST_REPLY: begin
				if (cmd_q != ose_pkg::CMD_EXISTS && cmd_q != ose_pkg::CMD_NEXT
						&& cmd_q != ose_pkg::CMD_PREV) begin
					rf_d = 1'b0;
				end
				if (cmd_q == ose_pkg::CMD_EXISTS) begin
					rk_d = '0;
				end
				if (!rv_q) begin
					rv_d    = 1'b1;
					state_d = ose_pkg::ST_IDLE;
				end
			end
			default: state_d = ose_pkg::ST_IDLE;
		endcase
	end

	`OSE_ASSERT_IMPL(a_count_bound, clk, arst_n, count_q <= CW'(CAPACITY))
	`OSE_ASSERT_IMPL(a_rsp_hold, clk, arst_n, rv_q && !rsp.ready |=> rv_q && $stable(rk_q))
	`OSE_ASSERT_IMPL(a_busy_no_accept, clk, arst_n, state_q != ose_pkg::ST_IDLE |-> !cmd.ready)
	`OSE_ASSERT_NEVER(a_no_accept_with_rsp, clk, arst_n, cmd.ready && rv_q)
endmodule
